### rtl/bole_pkg.sv
// Package for the bounded ordered list engine: sizes, operation and status codes, state encoding.
// Used by the interfaces and the engine; depends on nothing.
`default_nettype none
package bole_pkg;
  localparam int CAPACITY   = 64;
  localparam int ITEM_WIDTH = 32;
  localparam int CFG_W      = 7;
  localparam int IDX_W      = $clog2(CAPACITY + 1);
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CMP_W      = (IDX_W > CFG_W) ? IDX_W : CFG_W;
  localparam int OP_W       = 3;
  localparam int ST_W       = 3;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [IDX_W-1:0] NIL = IDX_W'(CAPACITY);
  localparam logic [CFG_W-1:0] MAX_ITEMS_RST = CFG_W'(64);
  localparam logic [PADDR_W-3:0] REG_MAX_ITEMS = '0;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_FIRST  = 3'd2;
  localparam logic [OP_W-1:0] OP_NEXT   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_NULL_ITEM = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;
  localparam logic [ST_W-1:0] ST_END       = 3'd5;
  localparam logic [ST_W-1:0] ST_NO_CURSOR = 3'd6;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WALK  = 6'b000010,
    S_READW = 6'b000100,
    S_NEXTL = 6'b001000,
    S_APP2  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  function automatic logic is_slot(input logic [IDX_W-1:0] i);
    return i < NIL;
  endfunction
endpackage
`default_nettype wire

### rtl/bole_if.sv
// Handshake channels of the list engine: one for operation beats, one for result beats.
// Depends on bole_pkg for the field widths.
`default_nettype none
interface bole_in_if;
  logic                           valid;
  logic                           ready;
  logic [bole_pkg::OP_W-1:0]      operation;
  logic [bole_pkg::ITEM_WIDTH-1:0] item_value;
  modport source (output valid, operation, item_value, input ready);
  modport sink   (input valid, operation, item_value, output ready);
endinterface

interface bole_out_if;
  logic                            valid;
  logic                            ready;
  logic [bole_pkg::ST_W-1:0]       status;
  logic [bole_pkg::ITEM_WIDTH-1:0] item_out;
  logic [bole_pkg::IDX_W-1:0]      item_count;
  modport source (output valid, status, item_out, item_count, input ready);
  modport sink   (input valid, status, item_out, item_count, output ready);
endinterface
`default_nettype wire

### rtl/bounded_ordered_list_engine.sv
// Bounded ordered list engine: a doubly linked list of nonzero words in slot RAMs.
// Depends on bole_pkg, bole_if (bole_in_if, bole_out_if) and bole_ram.
//
// Usage: operation beats enter on in_ch (append, remove value, cursor to first,
// cursor next, search value); each gives exactly one result beat on out_ch with
// status, the item under the cursor and the entry count after the operation.
// One operation is worked on at a time; in_ch.ready is high only while idle.
// Remove and search walk the list from the head until a match or the end; the
// walk visits up to count entries, one linked entry per cycle, set by the single
// read port of the word and link RAMs.
// A result sits in an output register; the next operation is accepted while it
// waits, and a further result waits in an emit state until out_ch is taken.
// max_items is written through the APB port at address 0 and read back there.
// Reset (rst_n low, synchronous) empties the list, clears the cursor and sets
// max_items to 64; the slot RAMs are not cleared, since only linked slots are read.
`default_nettype none
module bounded_ordered_list_engine (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  bole_in_if.sink                           in_ch,
  bole_out_if.source                        out_ch,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [bole_pkg::PADDR_W-1:0] cfg_paddr,
  input  wire logic [bole_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic      [bole_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                              cfg_pready
);
  localparam int IW = bole_pkg::IDX_W;
  localparam int AW = bole_pkg::ADDR_W;
  localparam int DW = bole_pkg::ITEM_WIDTH;

  bole_pkg::state_t state_r, state_nxt;
  logic [bole_pkg::CFG_W-1:0]    max_r;
  logic [bole_pkg::CAPACITY-1:0] free_r, free_nxt;
  logic [IW-1:0] head_r, head_nxt, tail_r, tail_nxt, cursor_r, cursor_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt, cur_r, cur_nxt, steps_r, steps_nxt;
  logic [bole_pkg::OP_W-1:0] op_r, op_nxt;
  logic [DW-1:0] val_r, val_nxt, res_item_r, res_item_nxt;
  logic [bole_pkg::ST_W-1:0] res_st_r, res_st_nxt;
  logic out_valid_r;
  logic [bole_pkg::ST_W-1:0] out_st_r;
  logic [DW-1:0] out_item_r;
  logic [IW-1:0] out_cnt_r;

  // RAM ports
  logic [AW-1:0] rd_addr;
  logic          w_we, n_we, p_we;
  logic [AW-1:0] w_addr, n_addr, p_addr;
  logic [DW-1:0] w_data, word_rd;
  logic [IW-1:0] n_data, p_data, next_rd, prev_rd;

  bole_ram #(.WIDTH(DW), .DEPTH(bole_pkg::CAPACITY)) u_words (
    .clk(clk), .we(w_we), .waddr(w_addr), .wdata(w_data), .raddr(rd_addr), .rdata(word_rd));
  bole_ram #(.WIDTH(IW), .DEPTH(bole_pkg::CAPACITY)) u_next (
    .clk(clk), .we(n_we), .waddr(n_addr), .wdata(n_data), .raddr(rd_addr), .rdata(next_rd));
  bole_ram #(.WIDTH(IW), .DEPTH(bole_pkg::CAPACITY)) u_prev (
    .clk(clk), .we(p_we), .waddr(p_addr), .wdata(p_data), .raddr(rd_addr), .rdata(prev_rd));

  // lowest free slot
  function automatic logic [AW-1:0] lowest_free(input logic [bole_pkg::CAPACITY-1:0] m);
    logic [AW-1:0] r;
    r = '0;
    for (int i = bole_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (m[i]) r = AW'(i);
    end
    return r;
  endfunction

  logic in_fire, out_free, full, cfg_wr;
  logic [AW-1:0] slot;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == bole_pkg::S_IDLE);
  assign out_free = !out_valid_r || out_ch.ready;
  assign slot = lowest_free(free_r);
  assign full = (bole_pkg::CMP_W'(cnt_r) >= bole_pkg::CMP_W'(max_r)) ||
                (cnt_r >= bole_pkg::NIL);

  // operation sequencer
  always_comb begin
    state_nxt = state_r;  free_nxt = free_r;  head_nxt = head_r;  tail_nxt = tail_r;
    cursor_nxt = cursor_r;  cnt_nxt = cnt_r;  cur_nxt = cur_r;  steps_nxt = steps_r;
    op_nxt = op_r;  val_nxt = val_r;  res_item_nxt = res_item_r;  res_st_nxt = res_st_r;
    rd_addr = cur_r[AW-1:0];
    w_we = 1'b0;  w_addr = slot;  w_data = val_r;
    n_we = 1'b0;  n_addr = slot;  n_data = bole_pkg::NIL;
    p_we = 1'b0;  p_addr = slot;  p_data = tail_r;
    unique case (state_r)
      bole_pkg::S_IDLE: begin
        if (in_fire) begin
          op_nxt = in_ch.operation;
          val_nxt = in_ch.item_value;
          res_item_nxt = '0;
          res_st_nxt = bole_pkg::ST_OK;
          state_nxt = bole_pkg::S_EMIT;
          unique case (in_ch.operation)
            bole_pkg::OP_APPEND: begin
              if (in_ch.item_value == '0) begin
                res_st_nxt = bole_pkg::ST_NULL_ITEM;
              end else if (full) begin
                res_st_nxt = bole_pkg::ST_FULL;
              end else begin
                w_we = 1'b1;  w_data = in_ch.item_value;
                p_we = 1'b1;
                if (bole_pkg::is_slot(tail_r)) begin
                  n_we = 1'b1;  n_addr = tail_r[AW-1:0];  n_data = IW'(slot);
                end else begin
                  head_nxt = IW'(slot);
                end
                tail_nxt = IW'(slot);
                free_nxt[slot] = 1'b0;
                cnt_nxt = cnt_r + 1'b1;
                cur_nxt = IW'(slot);
                state_nxt = bole_pkg::S_APP2;
              end
            end
            bole_pkg::OP_REMOVE, bole_pkg::OP_SEARCH: begin
              if (in_ch.item_value == '0) begin
                res_st_nxt = bole_pkg::ST_NULL_ITEM;
              end else if (!bole_pkg::is_slot(head_r)) begin
                if (in_ch.operation == bole_pkg::OP_SEARCH) begin
                  res_st_nxt = bole_pkg::ST_EMPTY;
                  cursor_nxt = bole_pkg::NIL;
                end else begin
                  res_st_nxt = bole_pkg::ST_NOT_FOUND;
                end
              end else begin
                rd_addr = head_r[AW-1:0];
                cur_nxt = head_r;
                steps_nxt = '0;
                state_nxt = bole_pkg::S_WALK;
              end
            end
            bole_pkg::OP_FIRST: begin
              if (!bole_pkg::is_slot(head_r)) begin
                res_st_nxt = bole_pkg::ST_EMPTY;
                cursor_nxt = bole_pkg::NIL;
              end else begin
                rd_addr = head_r[AW-1:0];
                cur_nxt = head_r;
                cursor_nxt = head_r;
                state_nxt = bole_pkg::S_READW;
              end
            end
            bole_pkg::OP_NEXT: begin
              if (!bole_pkg::is_slot(cursor_r)) begin
                res_st_nxt = bole_pkg::ST_NO_CURSOR;
              end else begin
                rd_addr = cursor_r[AW-1:0];
                cur_nxt = cursor_r;
                state_nxt = bole_pkg::S_NEXTL;
              end
            end
            default: ;
          endcase
        end
      end
      // second link write of an append: terminate the new tail
      bole_pkg::S_APP2: begin
        n_we = 1'b1;  n_addr = cur_r[AW-1:0];  n_data = bole_pkg::NIL;
        state_nxt = bole_pkg::S_EMIT;
      end
      // one linked entry per cycle: data of cur_r is on the RAM outputs
      bole_pkg::S_WALK: begin
        if (word_rd == val_r) begin
          state_nxt = bole_pkg::S_EMIT;
          if (op_r == bole_pkg::OP_REMOVE) begin
            if (bole_pkg::is_slot(prev_rd)) begin
              n_we = 1'b1;  n_addr = prev_rd[AW-1:0];  n_data = next_rd;
            end else begin
              head_nxt = next_rd;
            end
            if (bole_pkg::is_slot(next_rd)) begin
              p_we = 1'b1;  p_addr = next_rd[AW-1:0];  p_data = prev_rd;
            end else begin
              tail_nxt = prev_rd;
            end
            if (cursor_r == cur_r) cursor_nxt = bole_pkg::NIL;
            free_nxt[cur_r[AW-1:0]] = 1'b1;
            if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
          end else begin
            cursor_nxt = cur_r;
            res_item_nxt = word_rd;
          end
        end else if (!bole_pkg::is_slot(next_rd) ||
                     steps_r == IW'(bole_pkg::CAPACITY - 1)) begin
          state_nxt = bole_pkg::S_EMIT;
          res_st_nxt = bole_pkg::ST_NOT_FOUND;
          if (op_r == bole_pkg::OP_SEARCH) cursor_nxt = bole_pkg::NIL;
        end else begin
          rd_addr = next_rd[AW-1:0];
          cur_nxt = next_rd;
          steps_nxt = steps_r + 1'b1;
        end
      end
      // link of the cursor entry is on the RAM outputs
      bole_pkg::S_NEXTL: begin
        if (!bole_pkg::is_slot(next_rd)) begin
          cursor_nxt = bole_pkg::NIL;
          res_st_nxt = bole_pkg::ST_END;
          state_nxt = bole_pkg::S_EMIT;
        end else begin
          rd_addr = next_rd[AW-1:0];
          cur_nxt = next_rd;
          cursor_nxt = next_rd;
          state_nxt = bole_pkg::S_READW;
        end
      end
      bole_pkg::S_READW: begin
        res_item_nxt = word_rd;
        state_nxt = bole_pkg::S_EMIT;
      end
      bole_pkg::S_EMIT: begin
        if (out_free) state_nxt = bole_pkg::S_IDLE;
      end
      default: state_nxt = bole_pkg::S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bole_pkg::S_IDLE;
      free_r <= '1;
      head_r <= bole_pkg::NIL;
      tail_r <= bole_pkg::NIL;
      cursor_r <= bole_pkg::NIL;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      free_r <= free_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cursor_r <= cursor_nxt;
      cnt_r <= cnt_nxt;
      if (state_r == bole_pkg::S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    steps_r <= steps_nxt;
    op_r <= op_nxt;
    val_r <= val_nxt;
    res_item_r <= res_item_nxt;
    res_st_r <= res_st_nxt;
    if (state_r == bole_pkg::S_EMIT && out_free) begin
      out_st_r <= res_st_r;
      out_item_r <= res_item_r;
      out_cnt_r <= cnt_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_st_r;
  assign out_ch.item_out = out_item_r;
  assign out_ch.item_count = out_cnt_r;

  // APB register: max_items at address 0
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= bole_pkg::MAX_ITEMS_RST;
    end else if (cfg_wr && cfg_paddr[bole_pkg::PADDR_W-1:2] == bole_pkg::REG_MAX_ITEMS) begin
      max_r <= cfg_pwdata[bole_pkg::CFG_W-1:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[bole_pkg::PADDR_W-1:2] == bole_pkg::REG_MAX_ITEMS) ?
                      bole_pkg::PDATA_W'(max_r) : '0;

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready) else $error("accepted while busy");
  a_head_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == bole_pkg::NIL) == (cnt_r == '0)) else $error("head and count disagree");
  a_free_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(free_r) == bole_pkg::CAPACITY - int'(cnt_r)) else $error("free map off");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bole_pkg::S_WALK |-> steps_r < bole_pkg::NIL) else $error("walk overrun");
endmodule
`default_nettype wire

### rtl/bole_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package needed.
`default_nettype none
module bole_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
